[design/mmrc_pkg.sv]
package mmrc_pkg;

  // Stream widths: fields packed from bit 0 up, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned OUT_DATA_W = 136;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned NUM_W      = 5;

  // Result queue depth; two slots stay free for a descriptor that emits twice.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_CNT_W = 3;

  // Legacy segment kinds
  localparam logic [KIND_W-1:0] KIND_USABLE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RESERVED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACPI       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NVS        = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PERSISTENT = 3'd4;

  // UEFI memory type codes that map to something other than reserved
  localparam logic [31:0] EFI_LOADER_CODE      = 32'd1;
  localparam logic [31:0] EFI_LOADER_DATA      = 32'd2;
  localparam logic [31:0] EFI_BOOT_SVC_CODE    = 32'd3;
  localparam logic [31:0] EFI_BOOT_SVC_DATA    = 32'd4;
  localparam logic [31:0] EFI_CONVENTIONAL     = 32'd7;
  localparam logic [31:0] EFI_ACPI_RECLAIM     = 32'd9;
  localparam logic [31:0] EFI_ACPI_NVS         = 32'd10;
  localparam logic [31:0] EFI_PERSISTENT       = 32'd14;

  typedef struct packed {
    logic [63:0]       from_addr;
    logic [63:0]       to_addr;
    logic [KIND_W-1:0] kind;
    logic              last;
  } desc_t;

  typedef struct packed {
    logic [63:0]       seg_start;
    logic [63:0]       seg_length;
    logic [KIND_W-1:0] seg_kind;
    logic [NUM_W-1:0]  seg_number;
    logic              table_full;
    logic              last_of_run;
  } result_t;

  // Up to two results from one descriptor, compacted: r0 is filled first.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [KIND_W-1:0] classify(input logic [31:0] efi_type,
                                                  input logic        wb);
    logic [KIND_W-1:0] k;
    case (efi_type)
      EFI_LOADER_CODE, EFI_LOADER_DATA, EFI_BOOT_SVC_CODE,
      EFI_BOOT_SVC_DATA, EFI_CONVENTIONAL: k = wb ? KIND_USABLE : KIND_RESERVED;
      EFI_ACPI_RECLAIM: k = KIND_ACPI;
      EFI_ACPI_NVS:     k = KIND_NVS;
      EFI_PERSISTENT:   k = KIND_PERSISTENT;
      default:          k = KIND_RESERVED;
    endcase
    return k;
  endfunction

endpackage

[design/mmrc_ingest.sv]
module mmrc_ingest #(
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mmrc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  input  logic                              advance,
  output logic                              desc_valid,
  output mmrc_pkg::desc_t                   desc
);
  import mmrc_pkg::*;

  logic              valid_r;
  desc_t             desc_r;
  desc_t             desc_nxt;
  logic [63:0]       start;
  logic [51:0]       pages;
  logic [31:0]       efi_type;
  logic              wb;
  logic [63:0]       size;

  assign start    = in_tdata[63:0];
  assign pages    = in_tdata[115:64];
  assign efi_type = in_tdata[147:116];
  assign wb       = in_tdata[148];

  // page count to bytes, wraps at 2^64
  assign size = {12'd0, pages} << PAGE_SHIFT;

  always_comb begin
    desc_nxt.from_addr = start;
    desc_nxt.to_addr   = start + size;
    desc_nxt.kind      = classify(efi_type, wb);
    desc_nxt.last      = in_tlast;
  end

  assign in_tready  = !valid_r || advance;
  assign desc_valid = valid_r;
  assign desc       = desc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      desc_r <= desc_nxt;
    end
  end

endmodule

[design/mmrc_merge.sv]
module mmrc_merge #(
  parameter int unsigned MAX_SEGMENTS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  mmrc_pkg::desc_t desc,
  output mmrc_pkg::push_t push
);
  import mmrc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CNT_W:0] MAX_C = (CNT_W + 1)'(MAX_SEGMENTS);

  logic [63:0]       open_start_r, open_start_nxt;
  logic [63:0]       open_end_r,   open_end_nxt;
  logic [KIND_W-1:0] open_kind_r,  open_kind_nxt;
  logic              open_valid_r, open_valid_nxt;
  logic [CNT_W-1:0]  cnt_r,        cnt_nxt;
  logic              stopped_r,    stopped_nxt;

  logic              match;
  logic              emit_a;
  logic              emit_b;
  logic              full_a;
  logic              full_b;
  logic [CNT_W:0]    cnt_a1;
  logic [CNT_W-1:0]  cnt_b;
  logic [CNT_W:0]    cnt_b1;
  logic [63:0]       b_start;
  result_t           res_a;
  result_t           res_b;

  always_comb begin
    match  = open_valid_r && (desc.kind == open_kind_r) && (open_end_r == desc.from_addr);
    cnt_a1 = {1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1};
    emit_a = fire && !stopped_r && open_valid_r && !match;
    full_a = emit_a && (cnt_a1 >= MAX_C);
    // final descriptor flushes unless the table was already full or the mismatch emission filled it
    emit_b = fire && !stopped_r && desc.last && !full_a;
    cnt_b  = emit_a ? cnt_a1[CNT_W-1:0] : cnt_r;
    cnt_b1 = {1'b0, cnt_b} + {{CNT_W{1'b0}}, 1'b1};
    full_b = cnt_b1 >= MAX_C;
    b_start = match ? open_start_r : desc.from_addr;

    res_a.seg_start   = open_start_r;
    res_a.seg_length  = open_end_r - open_start_r;
    res_a.seg_kind    = open_kind_r;
    res_a.seg_number  = NUM_W'(cnt_r);
    res_a.table_full  = full_a;
    res_a.last_of_run = !emit_b;

    res_b.seg_start   = b_start;
    res_b.seg_length  = desc.to_addr - b_start;
    res_b.seg_kind    = desc.kind;
    res_b.seg_number  = NUM_W'(cnt_b);
    res_b.table_full  = full_b;
    res_b.last_of_run = 1'b1;

    push.n  = {1'b0, emit_a} + {1'b0, emit_b};
    push.r0 = emit_a ? res_a : res_b;
    push.r1 = res_b;
  end

  always_comb begin
    open_start_nxt = open_start_r;
    open_end_nxt   = open_end_r;
    open_kind_nxt  = open_kind_r;
    open_valid_nxt = open_valid_r;
    cnt_nxt        = cnt_r;
    stopped_nxt    = stopped_r;
    if (fire) begin
      if (desc.last) begin
        open_valid_nxt = 1'b0;
        cnt_nxt        = '0;
        stopped_nxt    = 1'b0;
      end else if (!stopped_r) begin
        if (match) begin
          open_end_nxt = desc.to_addr;
        end else if (!full_a) begin
          open_start_nxt = desc.from_addr;
          open_end_nxt   = desc.to_addr;
          open_kind_nxt  = desc.kind;
          open_valid_nxt = 1'b1;
        end
        cnt_nxt     = cnt_b;
        stopped_nxt = full_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_valid_r <= 1'b0;
      cnt_r        <= '0;
      stopped_r    <= 1'b0;
    end else begin
      open_valid_r <= open_valid_nxt;
      cnt_r        <= cnt_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    open_start_r <= open_start_nxt;
    open_end_r   <= open_end_nxt;
    open_kind_r  <= open_kind_nxt;
  end

endmodule

[design/mmrc_outq.sv]
module mmrc_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  mmrc_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output mmrc_pkg::result_t out_res
);
  import mmrc_pkg::*;

  result_t             slot_r   [Q_DEPTH];
  result_t             slot_nxt [Q_DEPTH];
  logic [Q_CNT_W-1:0]  cnt_r;
  logic [Q_CNT_W-1:0]  cnt_nxt;
  logic [Q_CNT_W-1:0]  base;
  logic                pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign out_res   = slot_r[0];
  // two free slots needed before the next descriptor may advance
  assign room      = cnt_r <= Q_CNT_W'(Q_DEPTH - 2);
  assign base      = cnt_r - {{(Q_CNT_W-1){1'b0}}, pop};
  assign cnt_nxt   = base + {1'b0, push.n};

  // head at slot 0; shift on pop, then land new results behind the survivors
  always_comb begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      if (pop && (i < Q_DEPTH - 1)) begin
        slot_nxt[i] = slot_r[(i + 1) % Q_DEPTH];
      end else begin
        slot_nxt[i] = slot_r[i];
      end
      if ((push.n != 2'd0) && (base == Q_CNT_W'(i))) begin
        slot_nxt[i] = push.r0;
      end
      if ((push.n == 2'd2) && (base + 3'd1 == Q_CNT_W'(i))) begin
        slot_nxt[i] = push.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

endmodule

[design/memory_map_region_coalescer_top.sv]
// UEFI memory map to e820-style segment table. Descriptors stream in one per
// beat (tlast marks the final descriptor of a map) and merged segments stream
// out, tlast on the last segment that a descriptor produced. Throughput is one
// descriptor per clock while the result queue has room; each one is held in
// the input register, then merged into the queue. A descriptor that closes one
// segment and also flushes on final yields two output beats. The 4-beat result
// queue accepts a new descriptor into the merge stage only while at most two
// results are waiting, so sustained rate is set by the output side whenever
// descriptors emit twice or the sink stalls. After MAX_SEGMENTS segments the
// last one carries the full flag and everything up to the final descriptor
// is dropped; the final descriptor always clears the state for the next map.
module memory_map_region_coalescer_top #(
  parameter int unsigned MAX_SEGMENTS = 32,
  parameter int unsigned PAGE_SHIFT   = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [63:0] region_start, [115:64] page_count, [147:116] efi_type,
  // [148] write_back_ok, [151:149] zero
  input  logic [mmrc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,   // final_descriptor
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [63:0] segment_start, [127:64] segment_length, [132:128] segment_number,
  // [133] table_full, [135:134] zero
  output logic [mmrc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [mmrc_pkg::KIND_W-1:0]     out_tuser,  // [2:0] segment_kind
  output logic                            out_tlast   // last_of_run
);
  import mmrc_pkg::*;

  logic    desc_valid;
  desc_t   desc;
  logic    room;
  logic    advance;
  push_t   push;
  result_t out_res;

  assign advance = desc_valid && room;

  mmrc_ingest #(
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_ingest (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  mmrc_merge #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .desc  (desc),
    .push  (push)
  );

  mmrc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {2'b00, out_res.table_full, out_res.seg_number,
                      out_res.seg_length, out_res.seg_start};
  assign out_tuser = out_res.seg_kind;
  assign out_tlast = out_res.last_of_run;

endmodule

[design/mmrc_checker.sv]
module mmrc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [mmrc_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mmrc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [mmrc_pkg::KIND_W-1:0]     out_tuser,
  input logic                            out_tlast
);
  import mmrc_pkg::*;

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast))
    else $error("input beat changed while stalled");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // a segment that fills the table is always the last one of its descriptor
  a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[133] |-> out_tlast)
    else $error("table_full beat without tlast");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= KIND_PERSISTENT))
    else $error("segment kind out of range");

  // the queue empties on reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind memory_map_region_coalescer_top mmrc_checker u_mmrc_checker (.*);
